/* hw/rtl/cmbp_pkg.sv */
package cmbp_pkg;

	localparam int NSTICK = 96;
	localparam int IDX_W = 7;
	localparam int BLK_W = 96;
	localparam int NMOVE = 8;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [NSTICK-1:0][IDX_W-1:0] map_t;

	localparam logic [1:0] REQ_RESTART = 2'd0;
	localparam logic [1:0] REQ_KEY = 2'd1;
	localparam logic [1:0] REQ_ENCRYPT = 2'd2;
	localparam logic [1:0] REQ_DECRYPT = 2'd3;

	localparam logic [1:0] CFG_XOR0 = 2'd0;
	localparam logic [1:0] CFG_XOR1 = 2'd1;
	localparam logic [1:0] CFG_XOR2 = 2'd2;

	localparam logic [6:0] FACE_RING [6][4][4] = '{
		'{'{7'h43,7'h42,7'h41,7'h40}, '{7'h33,7'h32,7'h31,7'h30},
		  '{7'h23,7'h22,7'h21,7'h20}, '{7'h13,7'h12,7'h11,7'h10}},
		'{'{7'h00,7'h04,7'h08,7'h0c}, '{7'h20,7'h24,7'h28,7'h2c},
		  '{7'h50,7'h54,7'h58,7'h5c}, '{7'h4f,7'h4b,7'h47,7'h43}},
		'{'{7'h0c,7'h0d,7'h0e,7'h0f}, '{7'h30,7'h34,7'h38,7'h3c},
		  '{7'h53,7'h52,7'h51,7'h50}, '{7'h1f,7'h1b,7'h17,7'h13}},
		'{'{7'h2f,7'h2b,7'h27,7'h23}, '{7'h0f,7'h0b,7'h07,7'h03},
		  '{7'h40,7'h44,7'h48,7'h4c}, '{7'h5f,7'h5b,7'h57,7'h53}},
		'{'{7'h3f,7'h3b,7'h37,7'h33}, '{7'h03,7'h02,7'h01,7'h00},
		  '{7'h10,7'h14,7'h18,7'h1c}, '{7'h5c,7'h5d,7'h5e,7'h5f}},
		'{'{7'h1c,7'h1d,7'h1e,7'h1f}, '{7'h2c,7'h2d,7'h2e,7'h2f},
		  '{7'h3c,7'h3d,7'h3e,7'h3f}, '{7'h4c,7'h4d,7'h4e,7'h4f}}
	};

	localparam logic [6:0] SLICE_RING [2][4][4] = '{
		'{'{7'h01,7'h05,7'h09,7'h0d}, '{7'h4e,7'h4a,7'h46,7'h42},
		  '{7'h51,7'h55,7'h59,7'h5d}, '{7'h21,7'h25,7'h29,7'h2d}},
		'{'{7'h14,7'h15,7'h16,7'h17}, '{7'h24,7'h25,7'h26,7'h27},
		  '{7'h34,7'h35,7'h36,7'h37}, '{7'h44,7'h45,7'h46,7'h47}}
	};

	function automatic map_t identity_map();
		map_t m;
		for (int i = 0; i < NSTICK; i++) m[i] = idx_t'(i);
		return m;
	endfunction

	// m[a] <- m[b] <- m[c] <- m[d] <- old m[a]
	function automatic map_t cyc4(map_t p, int a, int b, int c, int d);
		idx_t t;
		t = p[a];
		p[a] = p[b];
		p[b] = p[c];
		p[c] = p[d];
		p[d] = t;
		return p;
	endfunction

	function automatic map_t turn_face(map_t p, int f, int dir);
		int b;
		b = f * 16;
		if (dir == 0) begin
			p = cyc4(p, b + 0, b + 12, b + 15, b + 3);
			p = cyc4(p, b + 1, b + 8, b + 14, b + 7);
			p = cyc4(p, b + 2, b + 4, b + 13, b + 11);
			p = cyc4(p, b + 5, b + 9, b + 10, b + 6);
		end else begin
			p = cyc4(p, b + 0, b + 3, b + 15, b + 12);
			p = cyc4(p, b + 1, b + 7, b + 14, b + 8);
			p = cyc4(p, b + 2, b + 11, b + 13, b + 4);
			p = cyc4(p, b + 5, b + 6, b + 10, b + 9);
		end
		for (int k = 0; k < 4; k++) begin
			if (dir == 0)
				p = cyc4(p, FACE_RING[f][0][k], FACE_RING[f][3][k],
					FACE_RING[f][2][k], FACE_RING[f][1][k]);
			else
				p = cyc4(p, FACE_RING[f][0][k], FACE_RING[f][1][k],
					FACE_RING[f][2][k], FACE_RING[f][3][k]);
		end
		return p;
	endfunction

	function automatic map_t turn_slice(map_t p, int sl, int dir);
		for (int k = 0; k < 4; k++) begin
			if (dir == 0)
				p = cyc4(p, SLICE_RING[sl][0][k], SLICE_RING[sl][1][k],
					SLICE_RING[sl][2][k], SLICE_RING[sl][3][k]);
			else
				p = cyc4(p, SLICE_RING[sl][0][k], SLICE_RING[sl][3][k],
					SLICE_RING[sl][2][k], SLICE_RING[sl][1][k]);
		end
		return p;
	endfunction

	// source index of each entry after one move: new[i] = old[src[i]]
	function automatic map_t build_move(int nib);
		map_t p;
		int dir;
		int mv;
		p = identity_map();
		dir = nib % 2;
		mv = nib / 2;
		if (mv < 6) begin
			p = turn_face(p, mv, dir);
		end else if (mv == 6) begin
			p = turn_face(p, 1, dir);
			p = turn_slice(p, 0, dir);
		end else begin
			p = turn_face(p, 0, dir);
			p = turn_slice(p, 1, dir);
		end
		return p;
	endfunction

endpackage

/* hw/rtl/cmbp_turn.sv */
module cmbp_turn
	import cmbp_pkg::*;
(
	input  logic [3:0] nib,
	input  map_t       map_in,
	output map_t       map_out
);

	map_t cand [16];

	for (genvar m = 0; m < 16; m++) begin : g_move
		localparam map_t SRC = build_move(m);
		for (genvar i = 0; i < NSTICK; i++) begin : g_ent
			assign cand[m][i] = map_in[SRC[i]];
		end
	end

	assign map_out = cand[nib];

endmodule

/* hw/rtl/cmbp_key_sched.sv */
module cmbp_key_sched
	import cmbp_pkg::*;
(
	input  logic [31:0] key_word,
	input  map_t        map_in,
	output map_t        map_out
);

	map_t chain [NMOVE+1];

	assign chain[0] = map_in;

	// lowest nibble is applied first
	for (genvar s = 0; s < NMOVE; s++) begin : g_step
		cmbp_turn u_turn (
			.nib     (key_word[4*s +: 4]),
			.map_in  (chain[s]),
			.map_out (chain[s+1])
		);
	end

	assign map_out = chain[NMOVE];

endmodule

/* hw/rtl/cmbp_crypt.sv */
module cmbp_crypt
	import cmbp_pkg::*;
(
	input  map_t             map_in,
	input  logic             decrypt,
	input  logic [BLK_W-1:0] blk,
	input  logic [BLK_W-1:0] xpat,
	output logic [BLK_W-1:0] res
);

	logic [BLK_W-1:0] gath;
	logic [BLK_W-1:0] scat;
	logic [BLK_W-1:0] xin;

	assign xin = blk ^ xpat;

	always_comb begin
		for (int i = 0; i < NSTICK; i++)
			gath[i] = (map_in[i] < idx_t'(NSTICK)) ? blk[map_in[i]] : 1'b0;
	end

	// scatter: out bit map[i] takes bit i
	always_comb begin
		scat = '0;
		for (int j = 0; j < NSTICK; j++)
			for (int i = 0; i < NSTICK; i++)
				scat[j] = scat[j] | ((map_in[i] == idx_t'(j)) & xin[i]);
	end

	assign res = decrypt ? scat : (gath ^ xpat);

endmodule

/* hw/rtl/cube_move_bit_permutation_cipher.sv */
// Cube-move bit permutation cipher on 96-bit blocks.
// Request channel (in_valid / in_stall): req_type selects restart, key word,
// encrypt or decrypt; key_word and the block fields are used as that type needs.
// Result channel (out_valid / out_stall): one result per encrypt or decrypt
// request, none for restart or key word. Results come out in request order.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; index 0..2
// writes the XOR pattern words, higher indexes are ignored.
// A request is registered in the request stage on acceptance, and its result is
// registered in the result register when that stage fires, which a held result can delay.
// Throughput: one request per cycle unless a held result stalls it; the eight-move key
// schedule and the bit gather/scatter each sit in a single stage between the request
// register and the map/result registers.
// Reset: the permutation map returns to identity, the XOR words to zero and
// both stages empty.
// Stall: a valid result holds in the result register while out_stall is high; the
// request stage then holds an encrypt or decrypt, and in_stall rises while it is full.
module cube_move_bit_permutation_cipher
	import cmbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] key_word,
	input  logic [63:0] block_low,
	input  logic [31:0] block_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_low,
	output logic [31:0] result_high,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic             valid_s1;
	logic [1:0]       req_s1;
	logic [31:0]      key_s1;
	logic [BLK_W-1:0] blk_s1;
	logic             out_valid_q;
	logic [BLK_W-1:0] res_q;
	logic [31:0]      xor0_q, xor1_q, xor2_q;
	map_t             map_q;
	map_t             map_key;
	logic [BLK_W-1:0] res_d;
	logic             has_res;
	logic             s1_fire;
	logic             in_fire;

	assign cfg_ready = 1'b1;
	assign has_res = req_s1[1];
	assign s1_fire = valid_s1 && (!has_res || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_fire;
	assign in_fire = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor0_q <= '0;
			xor1_q <= '0;
			xor2_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_XOR0: xor0_q <= cfg_data;
				CFG_XOR1: xor1_q <= cfg_data;
				CFG_XOR2: xor2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_s1 <= req_type;
			key_s1 <= key_word;
			blk_s1 <= {block_high, block_low};
		end
	end

	cmbp_key_sched u_key_sched (
		.key_word (key_s1),
		.map_in   (map_q),
		.map_out  (map_key)
	);

	cmbp_crypt u_crypt (
		.map_in  (map_q),
		.decrypt (req_s1 == REQ_DECRYPT),
		.blk     (blk_s1),
		.xpat    ({xor2_q, xor1_q, xor0_q}),
		.res     (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= identity_map();
		end else if (s1_fire) begin
			unique case (req_s1)
				REQ_RESTART: map_q <= identity_map();
				REQ_KEY:     map_q <= map_key;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && has_res) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_res) res_q <= res_d;
	end

	assign out_valid = out_valid_q;
	assign result_low = res_q[63:0];
	assign result_high = res_q[95:64];

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && has_res && out_valid_q)
		else $error("request stage stalled without a held result");

	a_restart_id: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && req_s1 == REQ_RESTART |=> map_q == identity_map())
		else $error("map not identity after restart");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_fire && has_res))
		else $error("result appeared without an encrypt or decrypt");

endmodule

/* test/tb_cube_move_bit_permutation_cipher.sv */
`timescale 1ns / 100ps

module tb_cube_move_bit_permutation_cipher;
	import cmbp_pkg::*;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int TIMEOUT_CYCLES = 200000;

	localparam logic [6:0] FACE_TAB [6][4][4] = '{
		'{'{7'h43,7'h42,7'h41,7'h40}, '{7'h33,7'h32,7'h31,7'h30},
		  '{7'h23,7'h22,7'h21,7'h20}, '{7'h13,7'h12,7'h11,7'h10}},
		'{'{7'h00,7'h04,7'h08,7'h0c}, '{7'h20,7'h24,7'h28,7'h2c},
		  '{7'h50,7'h54,7'h58,7'h5c}, '{7'h4f,7'h4b,7'h47,7'h43}},
		'{'{7'h0c,7'h0d,7'h0e,7'h0f}, '{7'h30,7'h34,7'h38,7'h3c},
		  '{7'h53,7'h52,7'h51,7'h50}, '{7'h1f,7'h1b,7'h17,7'h13}},
		'{'{7'h2f,7'h2b,7'h27,7'h23}, '{7'h0f,7'h0b,7'h07,7'h03},
		  '{7'h40,7'h44,7'h48,7'h4c}, '{7'h5f,7'h5b,7'h57,7'h53}},
		'{'{7'h3f,7'h3b,7'h37,7'h33}, '{7'h03,7'h02,7'h01,7'h00},
		  '{7'h10,7'h14,7'h18,7'h1c}, '{7'h5c,7'h5d,7'h5e,7'h5f}},
		'{'{7'h1c,7'h1d,7'h1e,7'h1f}, '{7'h2c,7'h2d,7'h2e,7'h2f},
		  '{7'h3c,7'h3d,7'h3e,7'h3f}, '{7'h4c,7'h4d,7'h4e,7'h4f}}
	};

	localparam logic [6:0] INNER_TAB [2][4][4] = '{
		'{'{7'h01,7'h05,7'h09,7'h0d}, '{7'h4e,7'h4a,7'h46,7'h42},
		  '{7'h51,7'h55,7'h59,7'h5d}, '{7'h21,7'h25,7'h29,7'h2d}},
		'{'{7'h14,7'h15,7'h16,7'h17}, '{7'h24,7'h25,7'h26,7'h27},
		  '{7'h34,7'h35,7'h36,7'h37}, '{7'h44,7'h45,7'h46,7'h47}}
	};

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic [1:0]  rtype;
		logic [31:0] key;
		logic [63:0] lo;
		logic [31:0] hi;
		logic        typed;
		logic [63:0] exp_lo;
		logic [31:0] exp_hi;
	} row_t;

	typedef struct {
		logic [63:0] lo;
		logic [31:0] hi;
	} block_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [31:0] key_word;
	logic [63:0] block_low;
	logic [31:0] block_high;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_low;
	logic [31:0] result_high;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	logic [6:0]  perm [96];
	logic [31:0] pad_word [3];
	block_t      pending_blocks [$];
	row_t        rows [$];
	int          mismatches;
	int          n_results;
	int          cycles;
	int          burst_left;
	int          hold_left;
	int          stall_mode;
	logic        hold_done;

	cube_move_bit_permutation_cipher u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .key_word(key_word),
		.block_low(block_low), .block_high(block_high),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_low(result_low), .result_high(result_high),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// perm[a] <- perm[b] <- perm[c] <- perm[d] <- old perm[a]
	function automatic void rotate4(int a, int b, int c, int d);
		logic [6:0] t;
		t = perm[a];
		perm[a] = perm[b];
		perm[b] = perm[c];
		perm[c] = perm[d];
		perm[d] = t;
	endfunction

	function automatic void spin_face(int f, logic dir);
		int b;
		b = f * 16;
		if (!dir) begin
			rotate4(b + 0, b + 12, b + 15, b + 3);
			rotate4(b + 1, b + 8, b + 14, b + 7);
			rotate4(b + 2, b + 4, b + 13, b + 11);
			rotate4(b + 5, b + 9, b + 10, b + 6);
		end else begin
			rotate4(b + 0, b + 3, b + 15, b + 12);
			rotate4(b + 1, b + 7, b + 14, b + 8);
			rotate4(b + 2, b + 11, b + 13, b + 4);
			rotate4(b + 5, b + 6, b + 10, b + 9);
		end
		for (int k = 0; k < 4; k++) begin
			if (!dir)
				rotate4(FACE_TAB[f][0][k], FACE_TAB[f][3][k], FACE_TAB[f][2][k],
					FACE_TAB[f][1][k]);
			else
				rotate4(FACE_TAB[f][0][k], FACE_TAB[f][1][k], FACE_TAB[f][2][k],
					FACE_TAB[f][3][k]);
		end
	endfunction

	function automatic void spin_inner(int s, logic dir);
		for (int k = 0; k < 4; k++) begin
			if (!dir)
				rotate4(INNER_TAB[s][0][k], INNER_TAB[s][1][k], INNER_TAB[s][2][k],
					INNER_TAB[s][3][k]);
			else
				rotate4(INNER_TAB[s][0][k], INNER_TAB[s][3][k], INNER_TAB[s][2][k],
					INNER_TAB[s][1][k]);
		end
	endfunction

	// advance the sticker permutation by one request; returns 1 with a block
	// for encrypt and decrypt
	function automatic logic cipher_step(logic [1:0] rt, logic [31:0] key, logic [95:0] blk,
			output logic [95:0] res);
		logic [95:0] pad;
		logic [3:0]  nib;
		pad = {pad_word[2], pad_word[1], pad_word[0]};
		res = '0;
		case (rt)
			REQ_RESTART: begin
				for (int i = 0; i < 96; i++) perm[i] = 7'(i);
				return 1'b0;
			end
			REQ_KEY: begin
				for (int m = 0; m < 8; m++) begin
					nib = key[4*m +: 4];
					if (nib[3:1] < 6) begin
						spin_face(nib[3:1], nib[0]);
					end else if (nib[3:1] == 6) begin
						spin_face(1, nib[0]);
						spin_inner(0, nib[0]);
					end else begin
						spin_face(0, nib[0]);
						spin_inner(1, nib[0]);
					end
				end
				return 1'b0;
			end
			REQ_ENCRYPT: begin
				for (int i = 0; i < 96; i++)
					if (perm[i] < 96) res[i] = blk[perm[i]];
				res ^= pad;
				return 1'b1;
			end
			default: begin
				blk ^= pad;
				for (int i = 0; i < 96; i++)
					if (perm[i] < 96 && blk[i]) res[perm[i]] = 1'b1;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic offer_request(logic [1:0] rt, logic [31:0] key, logic [63:0] lo,
			logic [31:0] hi, logic typed, logic [63:0] elo, logic [31:0] ehi);
		logic [95:0] res;
		block_t b;
		in_valid <= 1'b1;
		req_type <= rt;
		key_word <= key;
		block_low <= lo;
		block_high <= hi;
		do @(posedge clk); while (in_stall);
		if (cipher_step(rt, key, {hi, lo}, res)) begin
			b.lo = typed ? elo : res[63:0];
			b.hi = typed ? ehi : res[95:64];
			pending_blocks.push_back(b);
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx != CFG_UNUSED) pad_word[idx] = data;
		cfg_valid <= 1'b0;
	endtask

	task automatic add_row(row_kind_e kind, logic [1:0] rt, logic [31:0] key, logic [63:0] lo,
			logic [31:0] hi, logic typed, logic [63:0] elo, logic [31:0] ehi);
		row_t r;
		r.kind = kind; r.rtype = rt; r.key = key; r.lo = lo; r.hi = hi;
		r.typed = typed; r.exp_lo = elo; r.exp_hi = ehi;
		rows.push_back(r);
	endtask

	task automatic random_phase(int n);
		logic [1:0] rt;
		int pick;
		for (int j = 0; j < n; j++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) rt = REQ_RESTART;
			else if (pick < 28) rt = REQ_KEY;
			else if (pick < 64) rt = REQ_ENCRYPT;
			else rt = REQ_DECRYPT;
			offer_request(rt, $urandom, {$urandom, $urandom}, $urandom, 1'b0, '0, '0);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("tb_cube_move_bit_permutation_cipher NOT OK");
			$finish;
		end
	end

	// result side: check, then pick the next stall value
	always @(posedge clk or negedge arst_n) begin
		block_t b;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results = n_results + 1;
				if (pending_blocks.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected block %h %h", result_high, result_low);
				end else begin
					b = pending_blocks.pop_front();
					if (b.lo !== result_low || b.hi !== result_high) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("block mismatch exp %h %h got %h %h",
								b.hi, b.lo, result_high, result_low);
					end
				end
			end
			if (!hold_done && n_results >= 40) begin
				hold_done = 1'b1;
				hold_left = 300;
			end
			if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 0);
					default: out_stall <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		row_t r;
		mismatches = 0;
		n_results = 0;
		cycles = 0;
		burst_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		stall_mode = 0;
		for (int i = 0; i < 96; i++) perm[i] = 7'(i);
		for (int i = 0; i < 3; i++) pad_word[i] = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_RESTART;
		key_word = '0;
		block_low = '0;
		block_high = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_XOR0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity map and zero pad straight after reset
		add_row(ROW_REQ, REQ_ENCRYPT, 32'h0, 64'h0, 32'h0, 1, 64'h0, 32'h0);
		add_row(ROW_REQ, REQ_ENCRYPT, 32'hffffffff, '1, '1, 1, '1, '1);
		add_row(ROW_REQ, REQ_DECRYPT, 32'h5a5a5a5a, 64'h0123456789abcdef, 32'h89abcdef,
			1, 64'h0123456789abcdef, 32'h89abcdef);
		add_row(ROW_REQ, REQ_KEY, 32'h76543210, '1, '1, 0, '0, '0);
		add_row(ROW_REQ, REQ_KEY, 32'hfedcba98, '0, '0, 0, '0, '0);
		add_row(ROW_REQ, REQ_ENCRYPT, 32'h0, 64'h0123456789abcdef, 32'hdeadbeef, 0, '0, '0);
		add_row(ROW_REQ, REQ_DECRYPT, 32'h0, 64'hfedcba9876543210, 32'h13572468, 0, '0, '0);
		add_row(ROW_REQ, REQ_KEY, 32'hffffffff, '0, '0, 0, '0, '0);
		add_row(ROW_REQ, REQ_KEY, 32'h00000000, '0, '0, 0, '0, '0);
		add_row(ROW_REQ, REQ_ENCRYPT, 32'h0, 64'h1, 32'h0, 0, '0, '0);
		add_row(ROW_REQ, REQ_DECRYPT, 32'h0, 64'h0, 32'h80000000, 0, '0, '0);
		// restart ignores whatever rides on the unused fields
		add_row(ROW_REQ, REQ_RESTART, 32'hffffffff, '1, '1, 0, '0, '0);
		add_row(ROW_REQ, REQ_ENCRYPT, 32'h0, 64'ha5a5a5a5c3c3c3c3, 32'h0f0f0f0f,
			1, 64'ha5a5a5a5c3c3c3c3, 32'h0f0f0f0f);
		add_row(ROW_CFG, CFG_XOR0, 32'hffffffff, '0, '0, 0, '0, '0);
		add_row(ROW_CFG, CFG_XOR1, 32'hffffffff, '0, '0, 0, '0, '0);
		add_row(ROW_CFG, CFG_XOR2, 32'hffffffff, '0, '0, 0, '0, '0);
		add_row(ROW_REQ, REQ_ENCRYPT, 32'h0, 64'h0, 32'h0, 1, '1, '1);
		add_row(ROW_REQ, REQ_DECRYPT, 32'h0, '1, '1, 1, 64'h0, 32'h0);
		add_row(ROW_REQ, REQ_KEY, 32'h13579bdf, '0, '0, 0, '0, '0);
		add_row(ROW_REQ, REQ_ENCRYPT, 32'h0, 64'h8000000000000001, 32'h1, 0, '0, '0);
		add_row(ROW_REQ, REQ_DECRYPT, 32'h0, 64'h00ff00ff00ff00ff, 32'hff00ff00, 0, '0, '0);
		// an index past the last register must leave the pad alone
		add_row(ROW_CFG, CFG_UNUSED, 32'h12345678, '0, '0, 0, '0, '0);
		add_row(ROW_REQ, REQ_ENCRYPT, 32'h0, 64'h0, 32'h0, 0, '0, '0);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_CFG) begin
				drain();
				write_reg(r.rtype, r.key);
			end else begin
				offer_request(r.rtype, r.key, r.lo, r.hi, r.typed, r.exp_lo, r.exp_hi);
			end
		end

		drain();
		write_reg(CFG_XOR0, $urandom);
		write_reg(CFG_XOR1, $urandom);
		write_reg(CFG_XOR2, $urandom);
		random_phase(170);

		drain();
		write_reg(CFG_XOR0, 32'h0);
		write_reg(CFG_XOR1, 32'hffffffff);
		write_reg(CFG_XOR2, 32'h0);
		random_phase(160);

		drain();
		write_reg(CFG_XOR0, $urandom);
		write_reg(CFG_XOR1, $urandom);
		write_reg(CFG_XOR2, 32'hffffffff);
		write_reg(CFG_UNUSED, $urandom);
		random_phase(170);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_blocks.size() == 0)
			$display("tb_cube_move_bit_permutation_cipher OK");
		else
			$display("tb_cube_move_bit_permutation_cipher NOT OK");
		$finish;
	end

endmodule
